// File: rtl/core/gcdlcm_pkg.sv
package gcdlcm_pkg;

    // Operand bits actually used; upper input bits are ignored.
    localparam int OPW   = 32;
    localparam int IN_W  = 32;
    localparam int ANS_W = 64;
    localparam int CNT_W = $clog2(OPW + 1);

    localparam logic FUNC_GCD = 1'b0;
    localparam logic FUNC_LCM = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_CHECK  = 6'b000100,
        S_QUOT   = 6'b001000,
        S_MUL    = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture operands, start first remainder
        logic div_step;     // one restoring division step
        logic euclid_next;  // (big, small) <= (small, rem), restart divider
        logic lcm_init;     // start a / gcd
        logic mul;          // product <= quotient * b
        logic out_load;     // fill the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic zero_in;      // an incoming operand is zero
        logic div_last;     // current step is the last of a division
        logic rem_zero;     // remainder of finished division is zero
        logic func;         // latched function select
    } t_sts;

endpackage

// File: rtl/core/gcdlcm_dp.sv
module gcdlcm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gcdlcm_pkg::t_cmd           i_cmd,
    output gcdlcm_pkg::t_sts           o_sts,
    input  logic                       i_func,
    input  logic [gcdlcm_pkg::IN_W-1:0]  i_left_operand,
    input  logic [gcdlcm_pkg::IN_W-1:0]  i_right_operand,
    output logic [gcdlcm_pkg::ANS_W-1:0] o_answer,
    output logic                       o_zero_operand
);
    import gcdlcm_pkg::*;

    logic [OPW-1:0]   a_in;
    logic [OPW-1:0]   b_in;
    logic [OPW-1:0]   r_a;
    logic [OPW-1:0]   r_b;
    logic             r_func;
    logic             r_zero;
    logic [OPW-1:0]   r_dvd;    // dividend shifting out, quotient shifting in
    logic [OPW-1:0]   r_rem;
    logic [OPW-1:0]   r_small;  // divisor; holds the gcd when done
    logic [CNT_W-1:0] r_cnt;
    logic [2*OPW-1:0] r_prod;
    logic [ANS_W-1:0] r_answer;
    logic             r_zflag;

    logic [OPW:0]     rem_sh;
    logic [OPW:0]     diff;
    logic             qbit;

    assign a_in = i_left_operand[OPW-1:0];
    assign b_in = i_right_operand[OPW-1:0];

    assign rem_sh = {r_rem, r_dvd[OPW-1]};
    assign diff   = rem_sh - {1'b0, r_small};
    assign qbit   = ~diff[OPW];

    assign o_sts.zero_in  = (a_in == '0) || (b_in == '0);
    assign o_sts.div_last = (r_cnt == CNT_W'(1));
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.func     = r_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load || i_cmd.euclid_next || i_cmd.lcm_init) begin
            r_cnt <= CNT_W'(OPW);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= a_in;
            r_b     <= b_in;
            r_func  <= i_func;
            r_zero  <= (a_in == '0) || (b_in == '0);
            r_rem   <= '0;
            r_dvd   <= (a_in > b_in) ? a_in : b_in;
            r_small <= (a_in > b_in) ? b_in : a_in;
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? diff[OPW-1:0] : rem_sh[OPW-1:0];
            r_dvd <= {r_dvd[OPW-2:0], qbit};
        end else if (i_cmd.euclid_next) begin
            r_dvd   <= r_small;
            r_small <= r_rem;
            r_rem   <= '0;
        end else if (i_cmd.lcm_init) begin
            r_dvd <= r_a;
            r_rem <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= r_dvd * r_b;
        end
        if (i_cmd.out_load) begin
            r_zflag <= r_zero;
            if (r_zero) begin
                r_answer <= '0;
            end else if (r_func == FUNC_LCM) begin
                r_answer <= ANS_W'(r_prod);
            end else begin
                r_answer <= ANS_W'(r_small);
            end
        end
    end

    assign o_answer       = r_answer;
    assign o_zero_operand = r_zflag;

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt != '0))
        else $error("division step with exhausted counter");

    a_zero_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_zero) |=> (o_answer == '0 && o_zero_operand))
        else $error("zero operand did not give zero answer");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(OPW))
        else $error("division counter out of range");

endmodule

// File: rtl/core/gcdlcm_ctrl.sv
module gcdlcm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  gcdlcm_pkg::t_sts i_sts,
    output gcdlcm_pkg::t_cmd o_cmd
);
    import gcdlcm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.zero_in ? S_FINISH : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.rem_zero) begin
                    o_cmd.euclid_next = 1'b1;
                    n_state           = S_DIV;
                end else if (i_sts.func == FUNC_LCM) begin
                    o_cmd.lcm_init = 1'b1;
                    n_state        = S_QUOT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_QUOT: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted transfer did not start work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while pending");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (o_cmd.div_step == 1'b0 && o_cmd.mul == 1'b0))
        else $error("input ready while datapath busy");

endmodule

// File: rtl/core/gcd_lcm_unit_core.sv
// Channel   Valid        Ready        Payload
// input     i_in_valid   o_in_ready   i_func, i_left_operand, i_right_operand
// output    o_out_valid  i_out_ready  o_answer, o_zero_operand
//
// One item at a time; a shared restoring divider gives one quotient bit per
// cycle, and each remainder is followed by a check state.
// gcd runs k remainder steps (k <= 45 at 32 bits); lcm adds a / gcd on the
// same divider and the 32x32 multiply. A zero operand goes straight to finish.
// Synchronous active-low reset clears the controller and the output valid.
// A stalled result holds the next one in its final state until the slot frees.
module gcd_lcm_unit_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_func,
    input  logic [gcdlcm_pkg::IN_W-1:0]  i_left_operand,
    input  logic [gcdlcm_pkg::IN_W-1:0]  i_right_operand,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [gcdlcm_pkg::ANS_W-1:0] o_answer,
    output logic                         o_zero_operand
);
    import gcdlcm_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    gcdlcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // operands, shared divider, multiplier and result register
    gcdlcm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_left_operand  (i_left_operand),
        .i_right_operand (i_right_operand),
        .o_answer        (o_answer),
        .o_zero_operand  (o_zero_operand)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

// Checks the gcd/lcm unit against its own arithmetic: every transfer
// into the block is turned into an expected answer and zero flag on the
// spot, and the results leaving the block are matched in order.
// The stimulus starts with directed operand pairs under both functions,
// then a random mix. The mix covers zero operands, full-width values,
// shared factors, small values, Fibonacci pairs (the longest Euclid runs)
// and exact multiples. The sender runs in bursts with gaps. The receiver
// stalls from a rolling mask.
module tb_top;
    import gcdlcm_pkg::*;

    localparam int RANDOM_ITEMS   = 528;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        logic            func;
        logic [IN_W-1:0] lhs;
        logic [IN_W-1:0] rhs;
    } t_op_item;

    typedef struct {
        logic [ANS_W-1:0] answer;
        logic             zero;
    } t_result;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               in_valid        = 1'b0;
    logic               in_func         = 1'b0;
    logic [IN_W-1:0]    in_lhs          = '0;
    logic [IN_W-1:0]    in_rhs          = '0;
    logic               out_ready       = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [ANS_W-1:0]   o_answer;
    logic               o_zero_operand;

    t_op_item           operand_queue[$];
    t_result            expected_results[$];
    t_op_item           drv_item;
    int                 burst_left      = 0;
    int                 gap_left        = 0;
    logic [31:0]        stall_mask      = '1;
    int                 mask_pos        = 0;
    int                 idle_cycles     = 0;
    int                 error_count     = 0;

    gcd_lcm_unit_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (in_func),
        .i_left_operand  (in_lhs),
        .i_right_operand (in_rhs),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_answer        (o_answer),
        .o_zero_operand  (o_zero_operand)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected answer for one item: Euclid on the masked operands, then
    // (a / gcd) * b for the lcm. Either operand zero gives 0 with the flag.
    function automatic t_result calc_gcd_lcm(input t_op_item it);
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] big;
        logic [63:0] lil;
        logic [63:0] rem;
        t_result     res;
        mask       = (64'd1 << OPW) - 64'd1;
        a          = {{(64 - IN_W){1'b0}}, it.lhs} & mask;
        b          = {{(64 - IN_W){1'b0}}, it.rhs} & mask;
        res.answer = '0;
        res.zero   = 1'b0;
        if (a == 0 || b == 0) begin
            res.zero = 1'b1;
        end else begin
            big = (a > b) ? a : b;
            lil = (a > b) ? b : a;
            rem = big % lil;
            while (rem != 0) begin
                big = lil;
                lil = rem;
                rem = big % lil;
            end
            if (it.func == FUNC_GCD) begin
                res.answer = lil;
            end else begin
                res.answer = (a / lil) * b;
            end
        end
        return res;
    endfunction

    function automatic t_op_item make_random_item();
        t_op_item        it;
        int unsigned     g;
        int unsigned     x;
        int unsigned     y;
        int unsigned     n;
        logic [IN_W-1:0] f0;
        logic [IN_W-1:0] f1;
        logic [IN_W-1:0] t;
        it.func = $urandom_range(0, 1) ? FUNC_LCM : FUNC_GCD;
        it.lhs  = $urandom;
        it.rhs  = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                // zero on one side or both
                case ($urandom_range(0, 2))
                    0:       it.lhs = '0;
                    1:       it.rhs = '0;
                    default: begin
                        it.lhs = '0;
                        it.rhs = '0;
                    end
                endcase
            end
            1, 2, 3: begin
                // full-width random, already set
            end
            4, 5, 6: begin
                g      = $urandom_range(1, 65535);
                x      = $urandom_range(1, 32767);
                y      = $urandom_range(1, 32767);
                it.lhs = g * x;
                it.rhs = g * y;
            end
            7: begin
                it.lhs = $urandom_range(1, 255);
                it.rhs = $urandom_range(1, 255);
            end
            8: begin
                // consecutive Fibonacci numbers: most remainder steps
                f0 = 1;
                f1 = 1;
                n  = $urandom_range(2, 45);
                repeat (n) begin
                    t  = f0 + f1;
                    f0 = f1;
                    f1 = t;
                end
                it.lhs = f1;
                it.rhs = f0;
            end
            default: begin
                x      = $urandom_range(1, 65535);
                y      = $urandom_range(1, 65535);
                it.lhs = x;
                it.rhs = x * y;
            end
        endcase
        if ($urandom_range(0, 1)) begin
            t      = it.lhs;
            it.lhs = it.rhs;
            it.rhs = t;
        end
        return it;
    endfunction

    // Driver: bursts of 1..8 items, then a gap of random length.
    always @(posedge i_clk) begin
        logic taken;
        taken = in_valid && o_in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (taken) begin
                expected_results.insert(expected_results.size(), calc_gcd_lcm(drv_item));
            end
            if (in_valid && !taken) begin
                // hold the item until the transfer happens
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (operand_queue.size() > 0) begin
                drv_item = operand_queue.pop_front();
                in_func  <= drv_item.func;
                in_lhs   <= drv_item.lhs;
                in_rhs   <= drv_item.rhs;
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, answer %0h zero_operand %0b",
                         $time, o_answer, o_zero_operand);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_answer !== want.answer) begin
                    $display("%0t: answer mismatch, expected %0h, actual %0h",
                             $time, want.answer, o_answer);
                    error_count++;
                end
                if (o_zero_operand !== want.zero) begin
                    $display("%0t: zero_operand mismatch, expected %0b, actual %0b",
                             $time, want.zero, o_zero_operand);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: a 32-bit mask walked one bit per cycle and
    // reloaded as always-ready, random, mostly ready or mostly stalled.
    always @(posedge i_clk) begin
        out_ready <= stall_mask[mask_pos];
        if (mask_pos == 31) begin
            mask_pos <= 0;
            case ($urandom_range(0, 3))
                0:       stall_mask <= '1;
                1:       stall_mask <= $urandom;
                2:       stall_mask <= $urandom | $urandom;
                default: stall_mask <= $urandom & $urandom;
            endcase
        end else begin
            mask_pos <= mask_pos + 1;
        end
    end

    // Watchdog: too long without a transfer on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [IN_W-1:0] dir_lhs[11];
        logic [IN_W-1:0] dir_rhs[11];
        t_op_item        it;
        // zero cases, extremes, coprime neighbors, worst-case Fibonacci, powers of two,
        // a small pair with a shared factor and alternating bit patterns
        dir_lhs = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h1,
                    32'hFFFF_FFFF, 32'd2971215073, 32'h8000_0000, 32'd12, 32'hAAAA_AAAA};
        dir_rhs = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                    32'hFFFF_FFFE, 32'd1836311903, 32'h4000_0000, 32'd18, 32'h5555_5555};
        for (int i = 0; i < 11; i++) begin
            it.lhs  = dir_lhs[i];
            it.rhs  = dir_rhs[i];
            it.func = FUNC_GCD;
            operand_queue.insert(operand_queue.size(), it);
            it.func = FUNC_LCM;
            operand_queue.insert(operand_queue.size(), it);
        end
        repeat (RANDOM_ITEMS) operand_queue.insert(operand_queue.size(), make_random_item());

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settle on falling edges so the queues are stable when read
        do begin
            @(negedge i_clk);
        end while (operand_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
